FILE: sv/pupr_pkg.sv
// Shared types and constants for the picture unit register port.
// Depends on nothing; used by pupr_front, pupr_back and the top level.
package pupr_pkg;

  // Sprite store size and command queue depth
  localparam int unsigned SPRITE_STORE_BYTES = 256;
  localparam int unsigned QUEUE_DEPTH        = 2;

  // Input word mode codes
  localparam logic [1:0] MODE_REG_WRITE = 2'd0;
  localparam logic [1:0] MODE_DMA_BYTE  = 2'd1;
  localparam logic [1:0] MODE_VBL_START = 2'd2;
  localparam logic [1:0] MODE_VBL_END   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Classified operation carried from front to back
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CONTROL,
    OP_MASK,
    OP_OAM_ADDR,
    OP_OAM_DATA,
    OP_SCROLL,
    OP_ADDR,
    OP_DATA,
    OP_DMA,
    OP_VBL_START,
    OP_VBL_END
  } op_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] register_index;
    logic [7:0] write_data;
    logic [7:0] dma_index;
  } in_word_t;

  typedef struct packed {
    logic        vram_write_valid;
    logic [15:0] vram_address;
    logic [7:0]  vram_data;
    logic [7:0]  oam_read_data;
    logic        nmi_request;
    logic        vblank_flag;
    logic [1:0]  base_nametable;
    logic        sprite_table_select;
    logic        background_table_select;
    logic [3:0]  render_mask;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
  } out_word_t;

  // Queue entry: decoded operation plus its operands
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] index;
  } cmd_t;

endpackage

FILE: sv/picture_unit_register_port_core.sv
// Picture unit register port: front classifier and queue, back executor.
// An accepted word passes the command queue, then the registered result stage.
// Throughput: one word per cycle while the result side is ready, set by the
// single registered sprite store read and at most one store write per command.
// Reset clears all port state; the sprite store reads as zero through
// per-entry written flags, so no clearing pass follows reset.
module picture_unit_register_port_core #(
  parameter int unsigned SpriteStoreBytes = pupr_pkg::SPRITE_STORE_BYTES,
  parameter int unsigned QueueDepth       = pupr_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pupr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pupr_pkg::out_word_t out_data_o
);

  logic           cmd_valid;
  logic           cmd_ready;
  pupr_pkg::cmd_t cmd;

  // Accept and classify words
  pupr_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // Execute commands and hold results
  pupr_back #(
    .SpriteStoreBytes(SpriteStoreBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: sv/pupr_front.sv
// Front end of the register port: accepts input words, classifies them
// and holds them in a short command queue. Depends on pupr_pkg.
module pupr_front #(
  parameter int unsigned QueueDepth = pupr_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pupr_pkg::in_word_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output pupr_pkg::cmd_t     cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  pupr_pkg::cmd_t       queue_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  pupr_pkg::cmd_t       cmd_new;
  logic                 push, pop;

  // Classify the incoming word
  always_comb begin
    cmd_new.data  = in_data_i.write_data;
    cmd_new.index = in_data_i.dma_index;
    cmd_new.op    = pupr_pkg::OP_NONE;
    case (in_data_i.mode)
      pupr_pkg::MODE_REG_WRITE: begin
        case (in_data_i.register_index)
          pupr_pkg::REG_CONTROL:  cmd_new.op = pupr_pkg::OP_CONTROL;
          pupr_pkg::REG_MASK:     cmd_new.op = pupr_pkg::OP_MASK;
          pupr_pkg::REG_STATUS:   cmd_new.op = pupr_pkg::OP_NONE;
          pupr_pkg::REG_OAM_ADDR: cmd_new.op = pupr_pkg::OP_OAM_ADDR;
          pupr_pkg::REG_OAM_DATA: cmd_new.op = pupr_pkg::OP_OAM_DATA;
          pupr_pkg::REG_SCROLL:   cmd_new.op = pupr_pkg::OP_SCROLL;
          pupr_pkg::REG_ADDR:     cmd_new.op = pupr_pkg::OP_ADDR;
          pupr_pkg::REG_DATA:     cmd_new.op = pupr_pkg::OP_DATA;
          default:                cmd_new.op = pupr_pkg::OP_NONE;
        endcase
      end
      pupr_pkg::MODE_DMA_BYTE:  cmd_new.op = pupr_pkg::OP_DMA;
      pupr_pkg::MODE_VBL_START: cmd_new.op = pupr_pkg::OP_VBL_START;
      pupr_pkg::MODE_VBL_END:   cmd_new.op = pupr_pkg::OP_VBL_END;
      default:                  cmd_new.op = pupr_pkg::OP_NONE;
    endcase
  end

  // Queue handshakes
  assign in_ready_o  = (count_q != FullCnt);
  assign cmd_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Count never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("command queue count out of range");

  // A push without pop grows the count by one
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("command queue count did not grow on push");

endmodule

FILE: sv/pupr_back.sv
// Back end of the register port: executes queued commands on the port
// state and sprite store, and holds the result word. Depends on pupr_pkg.
module pupr_back #(
  parameter int unsigned SpriteStoreBytes = pupr_pkg::SPRITE_STORE_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  pupr_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pupr_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = $clog2(SpriteStoreBytes);

  // Sprite store and per-entry written flags
  logic [7:0]                  store_mem [SpriteStoreBytes];
  logic [SpriteStoreBytes-1:0] written_q;

  // Port state
  logic [AW-1:0] sprite_addr_q, sprite_addr_d;
  logic          scroll_first_q, scroll_first_d;
  logic          addr_high_q, addr_high_d;
  logic [7:0]    addr_hi_q, addr_hi_d;
  logic [7:0]    addr_lo_q, addr_lo_d;
  logic [15:0]   data_offset_q, data_offset_d;
  logic [7:0]    scroll_x_q, scroll_x_d;
  logic [7:0]    scroll_y_q, scroll_y_d;
  logic [4:0]    control_q, control_d;
  logic [3:0]    mask_q, mask_d;
  logic          vblank_q, vblank_d;

  // Result stage
  logic                out_valid_q;
  pupr_pkg::out_word_t res_q, res_d;
  logic [7:0]          rd_data_q;
  logic                rd_written_q;
  logic                bypass_q;
  logic [7:0]          bypass_data_q;

  logic          fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          bypass_d;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  // Update port state for one command
  always_comb begin
    sprite_addr_d  = sprite_addr_q;
    scroll_first_d = scroll_first_q;
    addr_high_d    = addr_high_q;
    addr_hi_d      = addr_hi_q;
    addr_lo_d      = addr_lo_q;
    data_offset_d  = data_offset_q;
    scroll_x_d     = scroll_x_q;
    scroll_y_d     = scroll_y_q;
    control_d      = control_q;
    mask_d         = mask_q;
    vblank_d       = vblank_q;
    wr_en          = 1'b0;
    wr_addr        = sprite_addr_q;
    res_d          = '0;
    case (cmd_i.op)
      pupr_pkg::OP_CONTROL: begin
        control_d = {cmd_i.data[7], cmd_i.data[4], cmd_i.data[3], cmd_i.data[1:0]};
      end
      pupr_pkg::OP_MASK: begin
        mask_d = cmd_i.data[4:1];
      end
      pupr_pkg::OP_OAM_ADDR: begin
        sprite_addr_d = cmd_i.data[AW-1:0];
      end
      pupr_pkg::OP_OAM_DATA: begin
        wr_en         = 1'b1;
        wr_addr       = sprite_addr_q;
        sprite_addr_d = sprite_addr_q + AW'(1);
      end
      pupr_pkg::OP_SCROLL: begin
        if (scroll_first_q) begin
          scroll_x_d = cmd_i.data;
        end else begin
          scroll_y_d = cmd_i.data;
        end
        scroll_first_d = !scroll_first_q;
      end
      pupr_pkg::OP_ADDR: begin
        data_offset_d = '0;
        if (addr_high_q) begin
          addr_hi_d = cmd_i.data;
        end else begin
          addr_lo_d = cmd_i.data;
        end
        addr_high_d = !addr_high_q;
      end
      pupr_pkg::OP_DATA: begin
        res_d.vram_write_valid = 1'b1;
        res_d.vram_address     = {addr_hi_q, addr_lo_q} + data_offset_q;
        res_d.vram_data        = cmd_i.data;
        data_offset_d          = data_offset_q + 16'd1;
      end
      pupr_pkg::OP_DMA: begin
        wr_en   = 1'b1;
        wr_addr = cmd_i.index[AW-1:0];
      end
      pupr_pkg::OP_VBL_START: begin
        vblank_d          = 1'b1;
        res_d.nmi_request = control_q[4];
      end
      pupr_pkg::OP_VBL_END: begin
        vblank_d = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.vblank_flag             = vblank_d;
    res_d.base_nametable          = control_d[1:0];
    res_d.sprite_table_select     = control_d[2];
    res_d.background_table_select = control_d[3];
    res_d.render_mask             = mask_d;
    res_d.scroll_x                = scroll_x_d;
    res_d.scroll_y                = scroll_y_d;
  end

  // Forward a same-cycle store write to the read
  assign bypass_d = wr_en && (wr_addr == sprite_addr_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_addr_q  <= '0;
      scroll_first_q <= 1'b1;
      addr_high_q    <= 1'b1;
      addr_hi_q      <= '0;
      addr_lo_q      <= '0;
      data_offset_q  <= '0;
      scroll_x_q     <= '0;
      scroll_y_q     <= '0;
      control_q      <= '0;
      mask_q         <= '0;
      vblank_q       <= 1'b0;
      written_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (fire) begin
        sprite_addr_q  <= sprite_addr_d;
        scroll_first_q <= scroll_first_d;
        addr_high_q    <= addr_high_d;
        addr_hi_q      <= addr_hi_d;
        addr_lo_q      <= addr_lo_d;
        data_offset_q  <= data_offset_d;
        scroll_x_q     <= scroll_x_d;
        scroll_y_q     <= scroll_y_d;
        control_q      <= control_d;
        mask_q         <= mask_d;
        vblank_q       <= vblank_d;
        if (wr_en) begin
          written_q[wr_addr] <= 1'b1;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write the sprite store and register the read at the new sprite address
  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      store_mem[wr_addr] <= cmd_i.data;
    end
    if (fire) begin
      rd_data_q     <= store_mem[sprite_addr_d];
      rd_written_q  <= written_q[sprite_addr_d];
      bypass_q      <= bypass_d;
      bypass_data_q <= cmd_i.data;
      res_q         <= res_d;
    end
  end

  // Drive the result word; unwritten entries read as zero
  always_comb begin
    out_data_o = res_q;
    if (bypass_q) begin
      out_data_o.oam_read_data = bypass_data_q;
    end else if (rd_written_q) begin
      out_data_o.oam_read_data = rd_data_q;
    end else begin
      out_data_o.oam_read_data = '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A data write always reports a video memory write
  a_data_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.op == pupr_pkg::OP_DATA) |=> res_q.vram_write_valid)
    else $error("data write did not report a video memory write");

  // Vblank end leaves the status bit clear
  a_vbl_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.op == pupr_pkg::OP_VBL_END) |=> !vblank_q && !res_q.vblank_flag)
    else $error("vblank end did not clear status");

  // An address write restarts the data offset
  a_addr_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.op == pupr_pkg::OP_ADDR) |=> (data_offset_q == '0))
    else $error("address write did not clear data offset");

  // A sprite data write post-increments the sprite address
  a_oam_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.op == pupr_pkg::OP_OAM_DATA) |=>
      (sprite_addr_q == $past(sprite_addr_q) + AW'(1)))
    else $error("sprite address did not post-increment");

endmodule

FILE: bench/tb_top.sv
// Testbench for picture_unit_register_port_core: directed and random register port words.
// Checks each result word against a predictor of the port state held here.
// Depends on pupr_pkg (word types, mode codes, register indexes) and the top level RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned RANDOM_WORDS   = 1525;
  localparam int unsigned TAIL_CYCLES    = 10;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  pupr_pkg::in_word_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pupr_pkg::out_word_t out_data_o;

  // Shared run state
  bit                  idle_enable    = 1'b1;
  int unsigned         mismatch_count = 0;
  int unsigned         idle_cycles    = 0;
  pupr_pkg::out_word_t pending_port_words[$];

  // Predicted port state
  logic [7:0]  sprite_mem [pupr_pkg::SPRITE_STORE_BYTES];
  logic [7:0]  oam_addr;
  logic        scroll_first;
  logic        addr_high_next;
  logic [7:0]  addr_hi;
  logic [7:0]  addr_lo;
  logic [15:0] data_ofs;
  logic [7:0]  scroll_x_q;
  logic [7:0]  scroll_y_q;
  logic [1:0]  nametable_q;
  logic        sprite_tbl_q;
  logic        bg_tbl_q;
  logic        nmi_enable_q;
  logic [3:0]  mask_q;
  logic        vblank_q;

  picture_unit_register_port_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Put the predicted state to its reset values
  task automatic clear_port_model();
    foreach (sprite_mem[i]) sprite_mem[i] = '0;
    oam_addr       = '0;
    scroll_first   = 1'b1;
    addr_high_next = 1'b1;
    addr_hi        = '0;
    addr_lo        = '0;
    data_ofs       = '0;
    scroll_x_q     = '0;
    scroll_y_q     = '0;
    nametable_q    = '0;
    sprite_tbl_q   = 1'b0;
    bg_tbl_q       = 1'b0;
    nmi_enable_q   = 1'b0;
    mask_q         = '0;
    vblank_q       = 1'b0;
  endtask

  // Advance the predicted state by one input word and return the result word
  function automatic pupr_pkg::out_word_t next_port_word(pupr_pkg::in_word_t w);
    pupr_pkg::out_word_t r;
    r = '0;
    case (w.mode)
      pupr_pkg::MODE_REG_WRITE: begin
        case (w.register_index)
          pupr_pkg::REG_CONTROL: begin
            nametable_q  = w.write_data[1:0];
            sprite_tbl_q = w.write_data[3];
            bg_tbl_q     = w.write_data[4];
            nmi_enable_q = w.write_data[7];
          end
          pupr_pkg::REG_MASK: mask_q = w.write_data[4:1];
          pupr_pkg::REG_OAM_ADDR: oam_addr = w.write_data;
          pupr_pkg::REG_OAM_DATA: begin
            sprite_mem[oam_addr] = w.write_data;
            oam_addr = oam_addr + 8'd1;
          end
          pupr_pkg::REG_SCROLL: begin
            if (scroll_first) scroll_x_q = w.write_data;
            else scroll_y_q = w.write_data;
            scroll_first = ~scroll_first;
          end
          pupr_pkg::REG_ADDR: begin
            data_ofs = '0;
            if (addr_high_next) addr_hi = w.write_data;
            else addr_lo = w.write_data;
            addr_high_next = ~addr_high_next;
          end
          pupr_pkg::REG_DATA: begin
            r.vram_write_valid = 1'b1;
            r.vram_address = {addr_hi, 8'h00} + {8'h00, addr_lo} + data_ofs;
            r.vram_data = w.write_data;
            data_ofs = data_ofs + 16'd1;
          end
          default: ;
        endcase
      end
      pupr_pkg::MODE_DMA_BYTE: sprite_mem[w.dma_index] = w.write_data;
      pupr_pkg::MODE_VBL_START: begin
        vblank_q = 1'b1;
        r.nmi_request = nmi_enable_q;
      end
      default: vblank_q = 1'b0;
    endcase
    r.oam_read_data           = sprite_mem[oam_addr];
    r.vblank_flag             = vblank_q;
    r.base_nametable          = nametable_q;
    r.sprite_table_select     = sprite_tbl_q;
    r.background_table_select = bg_tbl_q;
    r.render_mask             = mask_q;
    r.scroll_x                = scroll_x_q;
    r.scroll_y                = scroll_y_q;
    return r;
  endfunction

  function automatic pupr_pkg::in_word_t make_word(logic [1:0] m, logic [2:0] ri,
                                                   logic [7:0] d, logic [7:0] di);
    pupr_pkg::in_word_t w;
    w.mode = m;
    w.register_index = ri;
    w.write_data = d;
    w.dma_index = di;
    return w;
  endfunction

  // Send one word: idle at random, hold valid until accepted, then predict
  task automatic send_word(pupr_pkg::in_word_t w);
    while (idle_enable && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_port_words.push_back(next_port_word(w));
  endtask

  // Register write with random unused DMA index
  task automatic write_reg(logic [2:0] ri, logic [7:0] d);
    send_word(make_word(pupr_pkg::MODE_REG_WRITE, ri, d, 8'($urandom)));
  endtask

  // Event word with random unused fields
  task automatic send_event(logic [1:0] m);
    send_word(make_word(m, 3'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // Hold off the sender until every expected word has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_port_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_control_and_mask();
    write_reg(pupr_pkg::REG_CONTROL, 8'hFF);
    write_reg(pupr_pkg::REG_MASK, 8'hFF);
    write_reg(pupr_pkg::REG_MASK, 8'h00);
    // only the ignored control bits set
    write_reg(pupr_pkg::REG_CONTROL, 8'h64);
    write_reg(pupr_pkg::REG_STATUS, 8'hFF);
  endtask

  task automatic test_sprite_store();
    write_reg(pupr_pkg::REG_OAM_ADDR, 8'hFF);
    // store at the top entry, address wraps to zero
    write_reg(pupr_pkg::REG_OAM_DATA, 8'hA5);
    send_word(make_word(pupr_pkg::MODE_DMA_BYTE, 3'd7, 8'h5A, 8'h00));
    send_word(make_word(pupr_pkg::MODE_DMA_BYTE, 3'd0, 8'hFF, 8'hFF));
    write_reg(pupr_pkg::REG_OAM_ADDR, 8'hFF);
    write_reg(pupr_pkg::REG_OAM_DATA, 8'h00);
  endtask

  task automatic test_scroll_address_data();
    write_reg(pupr_pkg::REG_SCROLL, 8'hFF);
    write_reg(pupr_pkg::REG_SCROLL, 8'h00);
    write_reg(pupr_pkg::REG_ADDR, 8'hFF);
    write_reg(pupr_pkg::REG_ADDR, 8'hFF);
    // address wraps past the top on the second write
    write_reg(pupr_pkg::REG_DATA, 8'h12);
    write_reg(pupr_pkg::REG_DATA, 8'h34);
    // a lone high byte write clears the running offset
    write_reg(pupr_pkg::REG_ADDR, 8'h00);
    write_reg(pupr_pkg::REG_DATA, 8'hFF);
    write_reg(pupr_pkg::REG_ADDR, 8'h00);
    write_reg(pupr_pkg::REG_DATA, 8'h00);
  endtask

  task automatic test_vblank();
    // end while not in vblank, then start with interrupts off
    send_event(pupr_pkg::MODE_VBL_END);
    send_event(pupr_pkg::MODE_VBL_START);
    write_reg(pupr_pkg::REG_CONTROL, 8'h80);
    send_event(pupr_pkg::MODE_VBL_START);
    send_event(pupr_pkg::MODE_VBL_START);
    send_event(pupr_pkg::MODE_VBL_END);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned n;
    int unsigned kind;
    logic [7:0]  di;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      // drop idling for a long stretch, then pause for all results between words 1000 and 1009
      idle_enable = !(sent >= 500 && sent < 750);
      if (sent >= 1000 && sent < 1010) wait_for_results();
      kind = $urandom_range(9);
      case (kind)
        0, 1: begin
          n = $urandom_range(1, 8);
          write_reg(pupr_pkg::REG_ADDR, 8'($urandom));
          write_reg(pupr_pkg::REG_ADDR, 8'($urandom));
          repeat (n) write_reg(pupr_pkg::REG_DATA, 8'($urandom));
          sent += n + 2;
        end
        2: begin
          write_reg(pupr_pkg::REG_SCROLL, 8'($urandom));
          write_reg(pupr_pkg::REG_SCROLL, 8'($urandom));
          sent += 2;
        end
        3: begin
          n = $urandom_range(1, 6);
          write_reg(pupr_pkg::REG_OAM_ADDR, 8'($urandom));
          repeat (n) write_reg(pupr_pkg::REG_OAM_DATA, 8'($urandom));
          sent += n + 1;
        end
        4: begin
          n = $urandom_range(1, 8);
          di = 8'($urandom);
          repeat (n) begin
            send_word(make_word(pupr_pkg::MODE_DMA_BYTE, 3'($urandom), 8'($urandom), di));
            di = ($urandom_range(1)) ? di + 8'd1 : 8'($urandom);
          end
          sent += n;
        end
        5: begin
          n = $urandom_range(0, 3);
          send_event(pupr_pkg::MODE_VBL_START);
          repeat (n) write_reg(3'($urandom), 8'($urandom));
          send_event(pupr_pkg::MODE_VBL_END);
          sent += n + 2;
        end
        6: begin
          write_reg($urandom_range(1) ? pupr_pkg::REG_CONTROL : pupr_pkg::REG_MASK,
                    8'($urandom));
          sent += 1;
        end
        default: begin
          // noise and broken sequences
          send_word(pupr_pkg::in_word_t'(21'($urandom)));
          sent += 1;
        end
      endcase
    end
    idle_enable = 1'b1;
  endtask

  // Result side: stall at random while idling is enabled
  always @(posedge clk_i) begin
    out_ready_i <= !idle_enable || ($urandom_range(99) >= 33);
  end

  task automatic check_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h actual %h", $time, field, exp_v, act_v);
    end
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    pupr_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_port_words.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result word %h with none expected", $time, out_data_o);
      end else begin
        exp_w = pending_port_words.pop_front();
        check_field("vram_write_valid", 16'(exp_w.vram_write_valid),
                    16'(out_data_o.vram_write_valid));
        check_field("vram_address", exp_w.vram_address, out_data_o.vram_address);
        check_field("vram_data", 16'(exp_w.vram_data), 16'(out_data_o.vram_data));
        check_field("oam_read_data", 16'(exp_w.oam_read_data), 16'(out_data_o.oam_read_data));
        check_field("nmi_request", 16'(exp_w.nmi_request), 16'(out_data_o.nmi_request));
        check_field("vblank_flag", 16'(exp_w.vblank_flag), 16'(out_data_o.vblank_flag));
        check_field("base_nametable", 16'(exp_w.base_nametable),
                    16'(out_data_o.base_nametable));
        check_field("sprite_table_select", 16'(exp_w.sprite_table_select),
                    16'(out_data_o.sprite_table_select));
        check_field("background_table_select", 16'(exp_w.background_table_select),
                    16'(out_data_o.background_table_select));
        check_field("render_mask", 16'(exp_w.render_mask), 16'(out_data_o.render_mask));
        check_field("scroll_x", 16'(exp_w.scroll_x), 16'(out_data_o.scroll_x));
        check_field("scroll_y", 16'(exp_w.scroll_y), 16'(out_data_o.scroll_y));
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("picture_unit_register_port_core regression: fail");
      $finish;
    end
  end

  initial begin
    clear_port_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_control_and_mask();
    test_sprite_store();
    test_scroll_address_data();
    test_vblank();
    test_random_traffic();
    // drain, then let any stray word show up
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_port_words.size() == 0) begin
      $display("picture_unit_register_port_core regression: pass");
    end else begin
      $display("picture_unit_register_port_core regression: fail");
    end
    $finish;
  end

endmodule
